// File: src/tla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tla_pkg
// Shared constants, register codes and control types of the lottery arbiter.
// ----------------------------------------------------------------------------
package tla_pkg;

    // Queue sizes used for the fill ratio
    localparam int SENSOR_QUEUE_DEPTH = 16;
    localparam int LINK_QUEUE_DEPTH   = 16;

    localparam int COUNT_W  = 5;
    localparam int CMP_W    = 9;   // holds any queue depth up to 256
    localparam int TICKET_W = 6;
    localparam int GRANT_W  = 2;
    localparam int GEN_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    localparam logic [GEN_W-1:0] GEN_RESET  = 32'd2463534242;
    localparam logic [GEN_W-1:0] GOLDEN_MUL = 32'h9E3779BB;

    localparam int XS_SHIFT_A = 12;
    localparam int XS_SHIFT_B = 25;
    localparam int XS_SHIFT_C = 27;
    localparam int TICKET_LSB = GEN_W - TICKET_W;

    // Grant codes
    localparam logic [GRANT_W-1:0] GRANT_A    = 2'd0;
    localparam logic [GRANT_W-1:0] GRANT_B    = 2'd1;
    localparam logic [GRANT_W-1:0] GRANT_LINK = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_B_URGENT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_URGENT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_L_URGENT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A_TKT_LO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A_TKT_HI  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_L_TKT_LO  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_L_TKT_HI  = 3'd6;

    // Register reset values
    localparam logic [TICKET_W-1:0] A_TKT_LO_RST = 6'd0;
    localparam logic [TICKET_W-1:0] A_TKT_HI_RST = 6'd31;
    localparam logic [TICKET_W-1:0] L_TKT_LO_RST = 6'd32;
    localparam logic [TICKET_W-1:0] L_TKT_HI_RST = 6'd47;

    typedef struct packed {
        logic load;   // capture ratios, advance generator
        logic mul;    // one pass through the multiplier
        logic emit;   // decide and load the output register
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;   // output register holds an item not yet taken
        logic out_taken;  // downstream takes the item this cycle
    } t_dp_stat;

endpackage

// File: src/tla_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tla_ctrl
// Sequencer: accept, two multiplier passes, decide and emit.
// ----------------------------------------------------------------------------
module tla_ctrl import tla_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    output logic     o_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL1 = 2'd1;
    localparam logic [1:0] S_MUL2 = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_can_emit;

    assign w_can_emit = !i_stat.out_busy || i_stat.out_taken;

    always_comb begin
        n_state    = r_state;
        o_ready    = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul = 1'b1;
                n_state   = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (w_can_emit) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> ##2 r_state == S_DONE)
        else $error("decide state not reached three cycles after accept");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.mul, o_cmd.emit}))
        else $error("more than one datapath command at once");
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> o_ready)
        else $error("not ready after emitting an item");
`endif

endmodule

// File: src/tla_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tla_dp
// Generator, shared multiplier, config registers, decision and output stage.
// ----------------------------------------------------------------------------
module tla_dp import tla_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic [COUNT_W-1:0]    i_b_count,
    input  logic [COUNT_W-1:0]    i_a_count,
    input  logic [COUNT_W-1:0]    i_link_count,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [GRANT_W-1:0]    o_grant,
    output logic                  o_urgent,
    output logic [TICKET_W-1:0]   o_ticket
);

    logic                r_b_urg_thr, r_a_urg_thr, r_l_urg_thr;
    logic [TICKET_W-1:0] r_a_lo, r_a_hi, r_l_lo, r_l_hi;
    logic [GEN_W-1:0]    r_gen;
    logic [GEN_W-1:0]    r_prod;
    logic                r_rb, r_ra, r_rl;
    logic                r_out_valid;
    logic [GRANT_W-1:0]  r_out_grant;
    logic                r_out_urgent;
    logic [TICKET_W-1:0] r_out_ticket;

    logic [GEN_W-1:0]    w_x1, w_x2, w_x3;
    logic [GEN_W-1:0]    w_mul;
    logic [TICKET_W-1:0] w_ticket;
    logic [GRANT_W-1:0]  w_grant;
    logic                w_urgent;

    // xorshift step on the stored generator
    assign w_x1 = r_gen ^ (r_gen >> XS_SHIFT_A);
    assign w_x2 = w_x1 ^ (w_x1 << XS_SHIFT_B);
    assign w_x3 = w_x2 ^ (w_x2 >> XS_SHIFT_C);

    assign w_mul    = r_prod * GOLDEN_MUL;
    assign w_ticket = r_prod[GEN_W-1:TICKET_LSB];

    always_comb begin
        w_urgent = 1'b1;
        if (r_rb >= r_b_urg_thr) begin
            w_grant = GRANT_B;
        end else if (r_ra >= r_a_urg_thr) begin
            w_grant = GRANT_A;
        end else if (r_rl >= r_l_urg_thr) begin
            w_grant = GRANT_LINK;
        end else begin
            w_urgent = 1'b0;
            if (w_ticket >= r_a_lo && w_ticket <= r_a_hi) begin
                w_grant = GRANT_A;
            end else if (w_ticket >= r_l_lo && w_ticket <= r_l_hi) begin
                w_grant = GRANT_LINK;
            end else begin
                w_grant = GRANT_B;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_urg_thr <= 1'b1;
            r_a_urg_thr <= 1'b1;
            r_l_urg_thr <= 1'b1;
            r_a_lo      <= A_TKT_LO_RST;
            r_a_hi      <= A_TKT_HI_RST;
            r_l_lo      <= L_TKT_LO_RST;
            r_l_hi      <= L_TKT_HI_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_B_URGENT: r_b_urg_thr <= i_cfg_data[0];
                REG_A_URGENT: r_a_urg_thr <= i_cfg_data[0];
                REG_L_URGENT: r_l_urg_thr <= i_cfg_data[0];
                REG_A_TKT_LO: r_a_lo      <= i_cfg_data;
                REG_A_TKT_HI: r_a_hi      <= i_cfg_data;
                REG_L_TKT_LO: r_l_lo      <= i_cfg_data;
                REG_L_TKT_HI: r_l_hi      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen       <= GEN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_gen <= w_x3;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_prod <= w_x3;
            // saturated count over depth is 1 exactly when count reaches depth
            r_rb <= CMP_W'(i_b_count)    >= CMP_W'(SENSOR_QUEUE_DEPTH);
            r_ra <= CMP_W'(i_a_count)    >= CMP_W'(SENSOR_QUEUE_DEPTH);
            r_rl <= CMP_W'(i_link_count) >= CMP_W'(LINK_QUEUE_DEPTH);
        end else if (i_cmd.mul) begin
            r_prod <= w_mul;
        end
        if (i_cmd.emit) begin
            r_out_grant  <= w_grant;
            r_out_urgent <= w_urgent;
            r_out_ticket <= w_ticket;
        end
    end

    assign o_stat.out_busy  = r_out_valid;
    assign o_stat.out_taken = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_grant     = r_out_grant;
    assign o_urgent    = r_out_urgent;
    assign o_ticket    = r_out_ticket;

`ifndef SYNTHESIS
    a_gen_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gen != '0)
        else $error("generator fell into the all-zero state");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !r_out_valid || i_out_ready)
        else $error("output item overwritten before it was taken");
    a_grant_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_grant == GRANT_A || r_out_grant == GRANT_B
                         || r_out_grant == GRANT_LINK))
        else $error("invalid grant code in output register");
`endif

endmodule

// File: src/threshold_lottery_arbiter.sv
// One result per item. The input is ready only while the sequencer is idle, so
// a new item is taken only after the last one is emitted; the sequencer runs the single
// 32x32 multiplier twice on each drawn ticket and waits for a free output register.
// Reset (synchronous, active low): generator reloads its seed, config registers
// return to their defaults, the output register empties.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_lottery_arbiter
// Three-queue arbiter: urgent fill override first, then a ticket lottery.
// ----------------------------------------------------------------------------
module threshold_lottery_arbiter import tla_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [4:0] sensor_b_count, [9:5] sensor_a_count, [14:10] link_count, [15] zero
    input  logic [15:0]           i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [1:0] grant, [7:2] ticket
    output logic [7:0]            o_m_axis_tdata,
    // [0] urgent
    output logic                  o_m_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd             w_cmd;
    t_dp_stat            w_stat;
    logic                w_ready;
    logic [GRANT_W-1:0]  w_grant;
    logic [TICKET_W-1:0] w_ticket;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = w_ready;

    tla_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_s_axis_tvalid),
        .o_ready (w_ready),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    tla_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_b_count    (i_s_axis_tdata[4:0]),
        .i_a_count    (i_s_axis_tdata[9:5]),
        .i_link_count (i_s_axis_tdata[14:10]),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_grant      (w_grant),
        .o_urgent     (o_m_axis_tuser),
        .o_ticket     (w_ticket)
    );

    assign o_m_axis_tdata = {w_ticket, w_grant};

endmodule

// File: dv/tb_threshold_lottery_arbiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_threshold_lottery_arbiter
// Self-checking bench for the three-queue lottery arbiter. A local model
// tracks the xorshift generator and the register file and predicts grant,
// urgent flag and ticket for every tick. Directed ticks cover the saturation,
// priority, zero-threshold and ticket-range corners; random phases follow
// with random register settings, random gaps on both streams and
// backpressure.
// ----------------------------------------------------------------------------
module tb_threshold_lottery_arbiter;
    import tla_pkg::*;

    localparam int DUT_LATENCY = 4;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [GRANT_W-1:0]  grant;
        logic                urgent;
        logic [TICKET_W-1:0] ticket;
    } t_grant;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // [4:0] sensor_b_count, [9:5] sensor_a_count, [14:10] link_count, [15] zero
    logic [15:0]           i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // [1:0] grant, [7:2] ticket
    logic [7:0]            o_m_axis_tdata;
    // [0] urgent
    logic                  o_m_axis_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    threshold_lottery_arbiter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data)
    );

    // Model state: generator and register file
    logic [GEN_W-1:0]    gen_state = GEN_RESET;
    logic                thr_b = 1'b1;
    logic                thr_a = 1'b1;
    logic                thr_l = 1'b1;
    logic [TICKET_W-1:0] a_lo = A_TKT_LO_RST;
    logic [TICKET_W-1:0] a_hi = A_TKT_HI_RST;
    logic [TICKET_W-1:0] l_lo = L_TKT_LO_RST;
    logic [TICKET_W-1:0] l_hi = L_TKT_HI_RST;

    t_grant grant_q[$];

    int err_count     = 0;
    int ticks_sent    = 0;
    int grants_seen   = 0;
    int urgent_seen   = 0;
    int lottery_seen  = 0;
    int reg_writes    = 0;
    bit src_jitter    = 1'b1;
    bit sink_jitter   = 1'b1;
    int sink_hold     = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic fill_ratio(input logic [COUNT_W-1:0] cnt, input int depth);
        int c;
        c = (int'(cnt) > depth) ? depth : int'(cnt);
        return logic'(c / depth);
    endfunction

    // Advance the generator and decide the grant for one tick
    function automatic t_grant predict_grant(input logic [COUNT_W-1:0] b, a, l);
        t_grant r;
        logic [GEN_W-1:0] x;
        logic [GEN_W-1:0] p;
        logic rb, ra, rl;
        x = gen_state;
        x = x ^ (x >> XS_SHIFT_A);
        x = x ^ (x << XS_SHIFT_B);
        x = x ^ (x >> XS_SHIFT_C);
        gen_state = x;
        p = x * GOLDEN_MUL;
        p = p * GOLDEN_MUL;
        r.ticket = p[GEN_W-1 -: TICKET_W];
        rb = fill_ratio(b, SENSOR_QUEUE_DEPTH);
        ra = fill_ratio(a, SENSOR_QUEUE_DEPTH);
        rl = fill_ratio(l, LINK_QUEUE_DEPTH);
        r.urgent = 1'b1;
        if (rb >= thr_b) begin
            r.grant = GRANT_B;
        end else if (ra >= thr_a) begin
            r.grant = GRANT_A;
        end else if (rl >= thr_l) begin
            r.grant = GRANT_LINK;
        end else begin
            r.urgent = 1'b0;
            if (r.ticket >= a_lo && r.ticket <= a_hi)
                r.grant = GRANT_A;
            else if (r.ticket >= l_lo && r.ticket <= l_hi)
                r.grant = GRANT_LINK;
            else
                r.grant = GRANT_B;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, want %0d (result %0d)", what, got, want, grants_seen);
        err_count++;
    endtask

    // Result sink: random stall per item, long hold when requested
    initial begin
        int stall;
        t_grant want;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = sink_jitter ? $urandom_range(0, 5) : 0;
            if (sink_hold > 0) begin
                stall = sink_hold;
                sink_hold = 0;
            end
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_axis_tvalid !== 1'b1);
            grants_seen++;
            if (grant_q.size() == 0) begin
                report_mismatch("result with no tick pending", o_m_axis_tdata, 0);
            end else begin
                want = grant_q.pop_front();
                if (o_m_axis_tdata[1:0] !== want.grant)
                    report_mismatch("grant", o_m_axis_tdata[1:0], want.grant);
                if (o_m_axis_tuser !== want.urgent)
                    report_mismatch("urgent", o_m_axis_tuser, want.urgent);
                if (o_m_axis_tdata[7:2] !== want.ticket)
                    report_mismatch("ticket", o_m_axis_tdata[7:2], want.ticket);
                if (want.urgent) urgent_seen++;
                else lottery_seen++;
            end
        end
    end

    task automatic send_tick(input logic [COUNT_W-1:0] b, a, l);
        int gap;
        gap = src_jitter ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, l, a, b};
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        grant_q.push_back(predict_grant(b, a, l));
        ticks_sent++;
    endtask

    // Stop offering ticks and wait until every grant has come back
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        wait (grant_q.size() == 0);
        @(posedge i_clk);
        repeat (DUT_LATENCY + 4) @(posedge i_clk);
    endtask

    // Hold valid across a burst; the caller lowers it
    task automatic cfg_put(input logic [CFG_IDX_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        reg_writes++;
        case (addr)
            REG_B_URGENT: thr_b = data[0];
            REG_A_URGENT: thr_a = data[0];
            REG_L_URGENT: thr_l = data[0];
            REG_A_TKT_LO: a_lo  = data;
            REG_A_TKT_HI: a_hi  = data;
            REG_L_TKT_LO: l_lo  = data;
            REG_L_TKT_HI: l_hi  = data;
            default: ;
        endcase
    endtask

    // Write the whole register file, plus one write to the unused index
    task automatic apply_regs(input logic tb_thr, ta_thr, tl_thr,
                              input logic [TICKET_W-1:0] alo, ahi, llo, lhi);
        // upper data bits of the 1-bit registers are junk and must be dropped
        cfg_put(REG_B_URGENT, {5'($urandom_range(0, 31)), tb_thr});
        cfg_put(REG_UNUSED, 6'($urandom_range(0, 63)));
        cfg_put(REG_A_URGENT, {5'($urandom_range(0, 31)), ta_thr});
        cfg_put(REG_L_URGENT, {5'($urandom_range(0, 31)), tl_thr});
        cfg_put(REG_A_TKT_LO, alo);
        cfg_put(REG_A_TKT_HI, ahi);
        cfg_put(REG_L_TKT_LO, llo);
        cfg_put(REG_L_TKT_HI, lhi);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [COUNT_W-1:0] pick_count();
        // mostly below the depth so the lottery gets reached
        if ($urandom_range(0, 9) < 7) return COUNT_W'($urandom_range(0, 15));
        return COUNT_W'($urandom_range(16, 31));
    endfunction

    function automatic logic [TICKET_W-1:0] pick_bound();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 6'd63 : 6'd0;
        return TICKET_W'($urandom_range(0, 63));
    endfunction

    task automatic test_reset_defaults();
        send_tick(5'd0,  5'd0,  5'd0);
        send_tick(5'd15, 5'd15, 5'd15);
        send_tick(5'd16, 5'd0,  5'd0);
        send_tick(5'd0,  5'd16, 5'd0);
        send_tick(5'd0,  5'd0,  5'd16);
        send_tick(5'd31, 5'd31, 5'd31);
        send_tick(5'd0,  5'd31, 5'd17);
        send_tick(5'd5,  5'd10, 5'd31);
        drain_results();
    endtask

    task automatic test_zero_thresholds();
        apply_regs(1'b0, 1'b1, 1'b1, A_TKT_LO_RST, A_TKT_HI_RST, L_TKT_LO_RST, L_TKT_HI_RST);
        send_tick(5'd0, 5'd31, 5'd31);
        send_tick(5'd0, 5'd0,  5'd0);
        drain_results();
        apply_regs(1'b1, 1'b0, 1'b1, A_TKT_LO_RST, A_TKT_HI_RST, L_TKT_LO_RST, L_TKT_HI_RST);
        send_tick(5'd0,  5'd0, 5'd31);
        send_tick(5'd16, 5'd0, 5'd0);
        drain_results();
        apply_regs(1'b1, 1'b1, 1'b0, A_TKT_LO_RST, A_TKT_HI_RST, L_TKT_LO_RST, L_TKT_HI_RST);
        send_tick(5'd0, 5'd0,  5'd0);
        send_tick(5'd0, 5'd16, 5'd0);
        drain_results();
    endtask

    task automatic test_ticket_ranges();
        // empty A range, link takes everything
        apply_regs(1'b1, 1'b1, 1'b1, 6'd40, 6'd10, 6'd0, 6'd63);
        repeat (3) send_tick(5'd0, 5'd0, 5'd0);
        drain_results();
        // full overlap, A must win
        apply_regs(1'b1, 1'b1, 1'b1, 6'd0, 6'd63, 6'd0, 6'd63);
        repeat (3) send_tick(5'd3, 5'd7, 5'd15);
        drain_results();
        // single-ticket A, empty link, B takes the rest
        apply_regs(1'b1, 1'b1, 1'b1, 6'd63, 6'd63, 6'd63, 6'd0);
        repeat (3) send_tick(5'd0, 5'd0, 5'd0);
        drain_results();
    endtask

    task automatic test_random_phases(input int phases, input int ticks_per_phase);
        for (int ph = 0; ph < phases; ph++) begin
            src_jitter  = (ph % 3) != 1;
            sink_jitter = (ph % 4) != 2;
            apply_regs($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                       $urandom_range(0, 3) != 0,
                       pick_bound(), pick_bound(), pick_bound(), pick_bound());
            repeat (ticks_per_phase) send_tick(pick_count(), pick_count(), pick_count());
            drain_results();
        end
        src_jitter  = 1'b1;
        sink_jitter = 1'b1;
    endtask

    task automatic test_output_backpressure();
        apply_regs(1'b1, 1'b1, 1'b1, 6'd0, 6'd20, 6'd21, 6'd41);
        src_jitter = 1'b0;
        sink_hold  = 80;
        repeat (25) send_tick(pick_count(), pick_count(), pick_count());
        src_jitter = 1'b1;
        drain_results();
    endtask

    task automatic test_sender_pause();
        repeat (10) send_tick(pick_count(), pick_count(), pick_count());
        drain_results();
        repeat (10) send_tick(pick_count(), pick_count(), pick_count());
        drain_results();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_zero_thresholds();
        test_ticket_ranges();
        test_output_backpressure();
        test_sender_pause();
        test_random_phases(8, 73);
        drain_results();

        $display("Covered %0d ticks over %0d register writes: %0d grants checked,",
                 ticks_sent, reg_writes, grants_seen);
        $display("  %0d by urgent override and %0d by lottery", urgent_seen, lottery_seen);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: threshold_lottery_arbiter.f
src/tla_pkg.sv
src/tla_ctrl.sv
src/tla_dp.sv
src/threshold_lottery_arbiter.sv
dv/tb_threshold_lottery_arbiter.sv
